@@ design/wbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Baseline subtractor package
// Shared types and constants for the waveform baseline subtractor.
// ----------------------------------------------------------------------------
package wbs_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam logic [6:0] COUNT_RESET = 7'd16;
  localparam logic [0:0] REG_BASELINE_COUNT = 1'b0;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [24:0] corrected;
    logic signed [23:0] baseline_mean;
    logic [23:0]        baseline_rms;
    logic               was_corrected;
    logic               last_out;
  } out_item_t;

endpackage

@@ design/wbs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/waveform_baseline_subtractor.sv @@
// ----------------------------------------------------------------------------
// Waveform baseline subtractor
// Subtracts the mean of the first N samples from every sample of a waveform
// and reports the baseline mean and RMS.
// ----------------------------------------------------------------------------
// Samples inside the baseline window are stored without a stall, since they
// produce no output transaction. When the window is full, a shared restoring
// unit works one bit per cycle: setup and products, the mean division, the
// variance division and the square root; then the result is loaded and the
// store read primed before the first stored sample is replayed. The N stored
// samples are then replayed at one per cycle while the output is not stalled.
// Samples after the window are taken one at a time: the input stalls until
// each corrected result has been accepted. A short waveform is replayed
// uncorrected with mean and RMS zero and was_corrected low. The window store
// needs no clearing after reset.
module waveform_baseline_subtractor #(
  parameter int MAX_WINDOW = wbs_pkg::MAX_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wbs_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wbs_pkg::out_item_t   out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import wbs_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS_DEF + AW;
  localparam int SQ_W = 2 * SAMPLE_BITS_DEF - 1 + AW;
  localparam int DW = SUM_W + 8;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_OUT    = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_MUL2   = 4'd3;
  localparam logic [3:0] S_MDIV   = 4'd4;
  localparam logic [3:0] S_VDIV   = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_REP    = 4'd8;
  localparam logic [3:0] S_SETUP  = 4'd9;
  localparam logic [3:0] S_SETUP2 = 4'd10;

  logic [3:0]  state;
  logic [6:0]  baseline_count;
  logic [CW-1:0] samples_seen;
  logic signed [SUM_W-1:0] running_sum;
  logic [SQ_W-1:0] running_square_sum;
  logic signed [23:0] mean_value;
  logic [23:0] rms_value;
  logic        baseline_ready;
  logic        wc;
  logic        last_hold;
  logic [CW-1:0] rep_idx;
  logic [CW-1:0] n_eff;

  // Shared shift-subtract unit.
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] divisor;
  logic [63:0] mag;
  logic [6:0]  cnt;
  logic        neg;
  logic [63:0] sq_bit;
  logic [2*SUM_W-1:0] sum_sq;
  logic [SQ_W+CW-1:0] n_sq_sum;

  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_rdata;

  logic in_acc;
  logic out_acc;
  logic cfg_wr;
  logic signed [15:0] s;
  logic [CW-1:0] seen_next;
  logic [CW-1:0] seen_next_rep;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = {25'd0, baseline_count};
  assign in_stall = (state != S_IDLE);
  assign s = in_data.sample;
  assign seen_next = samples_seen + CW'(1);
  assign seen_next_rep = rep_idx + CW'(1);

  always_comb begin
    n_eff = CW'(baseline_count);
    if (baseline_count == 7'd0) begin
      n_eff = CW'(1);
    end else if ({25'd0, baseline_count} > 32'(MAX_WINDOW)) begin
      n_eff = CW'(MAX_WINDOW);
    end
  end

  wbs_ram #(.WIDTH(16), .DEPTH(MAX_WINDOW)) u_window (
    .clk   (clk),
    .we    (in_acc && !baseline_ready && ({1'b0, samples_seen} < (CW+1)'(MAX_WINDOW))),
    .waddr (samples_seen[AW-1:0]),
    .wdata (s),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_addr = rep_idx[AW-1:0];
    if (state == S_REP && (!out_valid || out_acc)) begin
      ram_addr = seen_next_rep[AW-1:0];
    end
  end

  function automatic logic signed [24:0] sat_corr(input logic signed [40:0] v);
    if (v > 41'sd16777215) begin
      return 25'sd16777215;
    end else if (v < -41'sd16777216) begin
      return -25'sd16777216;
    end
    return v[24:0];
  endfunction

  logic [63:0] trial;
  logic [63:0] sq_try;
  assign trial  = {rem[62:0], quo[63]};
  assign sq_try = quo + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      baseline_count <= COUNT_RESET;
      samples_seen <= '0;
      running_sum <= '0;
      running_square_sum <= '0;
      mean_value <= '0;
      rms_value <= '0;
      baseline_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr && paddr == {REG_BASELINE_COUNT, 1'b0}) begin
        baseline_count <= pwdata[6:0];
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (baseline_ready) begin
              out_data.corrected <= sat_corr(41'(s) * 41'sd256 - 41'(mean_value));
              out_data.baseline_mean <= mean_value;
              out_data.baseline_rms <= rms_value;
              out_data.was_corrected <= 1'b1;
              out_data.last_out <= in_data.last_sample;
              out_valid <= 1'b1;
              state <= S_OUT;
              if (in_data.last_sample) begin
                baseline_ready <= 1'b0;
                samples_seen <= '0;
                running_sum <= '0;
                running_square_sum <= '0;
              end
            end else begin
              logic [CW-1:0] ns;
              ns = samples_seen;
              if ({1'b0, samples_seen} < (CW+1)'(MAX_WINDOW)) begin
                ns = seen_next;
                running_sum <= running_sum + SUM_W'(s);
                running_square_sum <= running_square_sum + SQ_W'(32'(s) * 32'(s));
              end
              samples_seen <= ns;
              last_hold <= in_data.last_sample;
              rep_idx <= '0;
              if (ns >= n_eff) begin
                wc <= 1'b1;
                state <= S_MUL1;
              end else if (in_data.last_sample) begin
                wc <= 1'b0;
                state <= S_RD;
              end
            end
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_MUL1: begin
          // mean numerator magnitude; divisor N
          neg <= running_sum[SUM_W-1];
          mag <= 64'(running_sum[SUM_W-1] ? -(SUM_W+1)'(running_sum) :
                     (SUM_W+1)'(running_sum));
          divisor <= 64'(samples_seen);
          state <= S_MUL2;
        end
        S_MUL2: begin
          rem <= '0;
          quo <= ((mag << 8) + (divisor >> 1)) << (64 - DW);
          sum_sq <= mag[SUM_W-1:0] * mag[SUM_W-1:0];
          n_sq_sum <= running_square_sum * samples_seen;
          cnt <= 7'(DW - 1);
          state <= S_MDIV;
        end
        S_MDIV: begin
          if (trial >= divisor) begin
            rem <= trial - divisor;
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd0) begin
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (cnt == 7'd127) begin
            if (quo[DW-1:0] > DW'(8388607)) begin
              mean_value <= neg ? -24'sd8388608 : 24'sd8388607;
            end else begin
              mean_value <= neg ? -$signed({1'b0, quo[22:0]}) : $signed({1'b0, quo[22:0]});
            end
            // The dividend carries 16 extra fraction bits for the root.
            rem <= '0;
            quo <= 64'(n_sq_sum - (SQ_W+CW)'(sum_sq)) << 16;
            divisor <= 64'((2*CW)'(samples_seen) * (2*CW)'(samples_seen));
            cnt <= 7'd63;
          end else begin
            if (trial >= divisor) begin
              rem <= trial - divisor;
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= trial;
              quo <= {quo[62:0], 1'b0};
            end
            cnt <= (cnt == 7'd0) ? 7'd127 : cnt - 7'd1;
            if (cnt == 7'd0) begin
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (cnt == 7'd127) begin
            mag <= quo;
            quo <= '0;
            sq_bit <= 64'd1 << 62;
            cnt <= 7'd32;
          end else begin
            if (mag >= sq_try) begin
              mag <= mag - sq_try;
              quo <= (quo >> 1) + sq_bit;
            end else begin
              quo <= quo >> 1;
            end
            sq_bit <= sq_bit >> 2;
            cnt <= cnt - 7'd1;
            if (cnt == 7'd1) begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          rms_value <= (quo > 64'd16777215) ? 24'hFFFFFF : quo[23:0];
          baseline_ready <= 1'b1;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_SETUP2;
        end
        S_SETUP2: begin
          state <= S_REP;
        end
        S_REP: begin
          if (!out_valid || out_acc) begin
            if (rep_idx == samples_seen) begin
              out_valid <= 1'b0;
              state <= S_IDLE;
              if (last_hold) begin
                baseline_ready <= 1'b0;
                samples_seen <= '0;
                running_sum <= '0;
                running_square_sum <= '0;
              end
            end else begin
              out_data.corrected <= wc ?
                sat_corr(41'($signed(ram_rdata)) * 41'sd256 - 41'(mean_value)) :
                sat_corr(41'($signed(ram_rdata)) * 41'sd256);
              out_data.baseline_mean <= wc ? mean_value : 24'sd0;
              out_data.baseline_rms <= wc ? rms_value : 24'd0;
              out_data.was_corrected <= wc;
              out_data.last_out <= last_hold && (seen_next_rep == samples_seen);
              out_valid <= 1'b1;
              rep_idx <= seen_next_rep;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ap_no_input_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  ap_seen_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, samples_seen} <= (CW+1)'(MAX_WINDOW))) else $error("window overrun");
endmodule
